@@ hdl/hsie_pkg.sv @@
`default_nettype none

package hsie_pkg;

    localparam int TABLE_SLOTS   = 8;
    localparam int SLOT_BITS     = $clog2(TABLE_SLOTS);
    localparam int KEY_BITS      = 32;
    localparam int HASH_BITS     = 32;
    localparam int COUNT_BITS    = $clog2(TABLE_SLOTS + 1);
    localparam int DECAY_SHIFT   = 5;
    localparam int PROBE_LIMIT   = TABLE_SLOTS + 16;
    localparam int PROBE_BITS    = $clog2(PROBE_LIMIT);
    localparam int STATUS_BITS   = 3;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_LIST = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_ADDED   = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_PRESENT = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_LISTED  = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 3'd4;

    typedef logic [SLOT_BITS-1:0]  slot_t;
    typedef logic [KEY_BITS-1:0]   key_t;
    typedef logic [HASH_BITS-1:0]  hash_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        logic  opcode;
        key_t  key;
        hash_t hash;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        slot_t                  slot;
        key_t                   out_key;
        hash_t                  out_hash;
        count_t                 entry_count;
        logic                   last;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/hash_set_insert_engine_unit.sv @@
// Add: takes 1 to 24 probes from the accepted start to the result strobe;
//   one probe per cycle through a shared index update and key compare.
// List: scans slots up to the last occupied slot; one result per key, or one empty result if none.
// busy is high from the accepted start until the final result; start may come in that cycle.
// Reset clears occupancy, entry count and the sequencer; slot contents are not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
`default_nettype none

module hash_set_insert_engine_unit
    import hsie_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire cmd_t    cmd,
    output logic         busy,
    output logic         result_valid,
    output result_t      result
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROBE = 2'd1;
    localparam logic [1:0] S_LIST  = 2'd2;

    logic [1:0]             state_reg, state_next;
    key_t                   slot_key_reg   [TABLE_SLOTS];
    hash_t                  slot_hash_reg  [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] occupied_reg, occupied_next;
    count_t                 count_reg, count_next;
    key_t                   key_reg, key_next;
    hash_t                  hash_reg, hash_next;
    hash_t                  perturb_reg, perturb_next;
    slot_t                  idx_reg, idx_next;
    logic [PROBE_BITS-1:0]  step_reg, step_next;
    logic                   valid_reg, valid_next;
    result_t                result_reg, result_next;
    logic                   write_en;

    hash_t                  perturb_step;
    slot_t                  idx_scaled;
    logic                   key_hit;
    logic                   above;

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        perturb_step = (step_reg != '0) ? (perturb_reg >> DECAY_SHIFT) : perturb_reg;
        idx_scaled   = (idx_reg << 2) + idx_reg;
        key_hit      = (slot_key_reg[idx_reg] == key_reg);
        above        = 1'b0;
        for (int j = 0; j < TABLE_SLOTS; j++)
        begin
            if (occupied_reg[j] && (slot_t'(j) > idx_reg))
            begin
                above = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        occupied_next = occupied_reg;
        count_next    = count_reg;
        key_next      = key_reg;
        hash_next     = hash_reg;
        perturb_next  = perturb_reg;
        idx_next      = idx_reg;
        step_next     = step_reg;
        valid_next    = 1'b0;
        result_next   = result_reg;
        write_en      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next     = cmd.key;
                    hash_next    = cmd.hash;
                    perturb_next = cmd.hash;
                    step_next    = '0;
                    if (cmd.opcode == OP_ADD)
                    begin
                        idx_next   = cmd.hash[SLOT_BITS-1:0];
                        state_next = S_PROBE;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_LIST;
                    end
                end
            end
            S_PROBE:
            begin
                if (!occupied_reg[idx_reg])
                begin
                    write_en               = 1'b1;
                    occupied_next[idx_reg] = 1'b1;
                    count_next             = count_reg + count_t'(1);
                    valid_next             = 1'b1;
                    result_next            = '{ST_ADDED, idx_reg, key_reg, hash_reg,
                                               count_reg + count_t'(1), 1'b1};
                    state_next             = S_IDLE;
                end
                else if (key_hit)
                begin
                    valid_next  = 1'b1;
                    result_next = '{ST_PRESENT, idx_reg, slot_key_reg[idx_reg],
                                    slot_hash_reg[idx_reg], count_reg, 1'b1};
                    state_next  = S_IDLE;
                end
                else if (step_reg == PROBE_BITS'(PROBE_LIMIT - 1))
                begin
                    valid_next  = 1'b1;
                    result_next = '{ST_FULL, slot_t'(0), key_t'(0), hash_t'(0),
                                    count_reg, 1'b1};
                    state_next  = S_IDLE;
                end
                else
                begin
                    perturb_next = perturb_step;
                    idx_next     = idx_scaled + perturb_step[SLOT_BITS-1:0] + slot_t'(1);
                    step_next    = step_reg + PROBE_BITS'(1);
                end
            end
            S_LIST:
            begin
                if (occupied_reg == '0)
                begin
                    valid_next  = 1'b1;
                    result_next = '{ST_EMPTY, slot_t'(0), key_t'(0), hash_t'(0),
                                    count_reg, 1'b1};
                    state_next  = S_IDLE;
                end
                else
                begin
                    if (occupied_reg[idx_reg])
                    begin
                        valid_next  = 1'b1;
                        result_next = '{ST_LISTED, idx_reg, slot_key_reg[idx_reg],
                                        slot_hash_reg[idx_reg], count_reg, !above};
                    end
                    if (!above)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + slot_t'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            occupied_reg <= '0;
            count_reg    <= '0;
            valid_reg    <= 1'b0;
            step_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            occupied_reg <= occupied_next;
            count_reg    <= count_next;
            valid_reg    <= valid_next;
            step_reg     <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        hash_reg    <= hash_next;
        perturb_reg <= perturb_next;
        idx_reg     <= idx_next;
        result_reg  <= result_next;
        if (write_en)
        begin
            slot_key_reg[idx_reg]  <= key_reg;
            slot_hash_reg[idx_reg] <= hash_reg;
        end
    end

endmodule

`default_nettype wire
